### hw/rtl/pip_pkg.sv
// shared constants, codes and controller/datapath interface types for the point-in-polygon block
`timescale 1ns / 1ps

package pip_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_W      = 32;
    localparam int AW           = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CROSS_W      = 11;
    localparam int TOT_W        = (CNT_W > CROSS_W) ? CNT_W : CROSS_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VTX_W        = 2 * COORD_W + 1;

    localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef struct packed {
        logic          wr_en;
        logic          rd_en;
        logic          start;
        logic          res_load;
        logic [AW-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic stall;
        logic busy;
    } sts_t;

endpackage

### hw/rtl/pip_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/pip_dpath.sv
// datapath: vertex store, edge sequencing, crossing test pipeline and crossing counters
`timescale 1ns / 1ps

module pip_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pip_pkg::cmd_t                     cmd,
    output pip_pkg::sts_t                     sts,
    input  logic signed [31:0]                point_u,
    input  logic signed [31:0]                point_v,
    input  logic                              closes_loop,
    output logic                              inside_res,
    output logic [pip_pkg::CROSS_W-1:0]       crossings
);

    import pip_pkg::*;

    logic signed [COORD_W-1:0] in_u;
    logic signed [COORD_W-1:0] in_v;
    logic [VTX_W-1:0]          wdata;
    logic [VTX_W-1:0]          rdata;
    logic                      ram_re;
    logic                      stall;

    logic signed [COORD_W-1:0] q_u;
    logic signed [COORD_W-1:0] q_v;
    logic                      q_mark;

    // vertex stage
    logic                      q_vld_reg, q_vld_next;
    logic                      close_reg, close_next;
    logic [1:0]                len_reg, len_next;
    logic signed [COORD_W-1:0] first_u_reg, first_u_next, first_v_reg, first_v_next;
    logic signed [COORD_W-1:0] prev_u_reg, prev_u_next, prev_v_reg, prev_v_next;
    logic signed [COORD_W-1:0] qry_u_reg, qry_v_reg;

    // edge stage
    logic                      e_vld_reg, e_vld_next;
    logic                      e_end_reg, e_end_next;
    logic                      e_commit_reg, e_commit_next;
    logic signed [COORD_W-1:0] e_au_reg, e_au_next, e_av_reg, e_av_next;
    logic signed [COORD_W-1:0] e_bu_reg, e_bu_next, e_bv_reg, e_bv_next;

    // difference stage
    logic                      a_hi, b_hi;
    logic signed [COORD_W-1:0] lo_u, lo_v, hi_u, hi_v;
    logic                      d_vld_reg, d_end_reg, d_commit_reg, d_str_reg;
    logic signed [DIFF_W-1:0]  d1_reg, d1_next, d2_reg, d2_next;
    logic signed [DIFF_W-1:0]  d3_reg, d3_next, d4_reg, d4_next;

    // product stage
    logic                      p_vld_reg, p_end_reg, p_commit_reg, p_str_reg;
    logic signed [PROD_W-1:0]  p1_reg, p1_next, p2_reg, p2_next;

    // counters
    logic                      cross_hit;
    logic [TOT_W-1:0]          pend_reg, pend_next, pend_sum;
    logic [TOT_W-1:0]          total_reg, total_next;
    logic                      inside_reg;
    logic [CROSS_W-1:0]        cross_reg;

    assign in_u  = point_u[COORD_W-1:0];
    assign in_v  = point_v[COORD_W-1:0];
    assign wdata = {closes_loop, in_u, in_v};

    assign q_mark = rdata[VTX_W-1];
    assign q_u    = rdata[2*COORD_W-1:COORD_W];
    assign q_v    = rdata[COORD_W-1:0];

    // a closing vertex holds the read for one cycle to emit the edge back to the loop start
    assign stall  = q_vld_reg && q_mark && !close_reg && (len_reg != 2'd0);
    assign ram_re = cmd.rd_en && !stall;

    assign sts.stall = stall;
    assign sts.busy  = q_vld_reg || e_vld_reg || d_vld_reg || p_vld_reg;

    pip_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.addr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (cmd.addr),
        .rdata (rdata)
    );

    assign q_vld_next = stall ? 1'b1 : cmd.rd_en;

    always_comb
    begin
        e_vld_next    = 1'b0;
        e_end_next    = 1'b0;
        e_commit_next = 1'b0;
        e_au_next     = prev_u_reg;
        e_av_next     = prev_v_reg;
        e_bu_next     = q_u;
        e_bv_next     = q_v;
        first_u_next  = first_u_reg;
        first_v_next  = first_v_reg;
        prev_u_next   = prev_u_reg;
        prev_v_next   = prev_v_reg;
        len_next      = len_reg;
        close_next    = close_reg;
        if (cmd.start)
        begin
            len_next   = 2'd0;
            close_next = 1'b0;
        end
        else if (q_vld_reg)
        begin
            if (close_reg)
            begin
                // closing edge; loops shorter than three vertices are dropped
                e_vld_next    = 1'b1;
                e_end_next    = 1'b1;
                e_commit_next = (len_reg == 2'd3);
                e_au_next     = q_u;
                e_av_next     = q_v;
                e_bu_next     = first_u_reg;
                e_bv_next     = first_v_reg;
                close_next    = 1'b0;
                len_next      = 2'd0;
            end
            else if (len_reg == 2'd0)
            begin
                first_u_next = q_u;
                first_v_next = q_v;
                prev_u_next  = q_u;
                prev_v_next  = q_v;
                len_next     = q_mark ? 2'd0 : 2'd1;
            end
            else
            begin
                e_vld_next  = 1'b1;
                prev_u_next = q_u;
                prev_v_next = q_v;
                len_next    = (len_reg == 2'd3) ? 2'd3 : len_reg + 2'd1;
                close_next  = q_mark;
            end
        end
    end

    // order the edge so lo is the lower end in v when it straddles the query
    assign a_hi = e_av_reg > qry_v_reg;
    assign b_hi = e_bv_reg > qry_v_reg;
    assign lo_u = a_hi ? e_bu_reg : e_au_reg;
    assign lo_v = a_hi ? e_bv_reg : e_av_reg;
    assign hi_u = a_hi ? e_au_reg : e_bu_reg;
    assign hi_v = a_hi ? e_av_reg : e_bv_reg;

    assign d1_next = {qry_u_reg[COORD_W-1], qry_u_reg} - {lo_u[COORD_W-1], lo_u};
    assign d2_next = {hi_v[COORD_W-1], hi_v} - {lo_v[COORD_W-1], lo_v};
    assign d3_next = {qry_v_reg[COORD_W-1], qry_v_reg} - {lo_v[COORD_W-1], lo_v};
    assign d4_next = {hi_u[COORD_W-1], hi_u} - {lo_u[COORD_W-1], lo_u};

    assign p1_next = d1_reg * d2_reg;
    assign p2_next = d3_reg * d4_reg;

    // query u left of the intersection, compared by cross-multiplication
    assign cross_hit = p_str_reg && (p1_reg < p2_reg);
    assign pend_sum  = pend_reg + TOT_W'(cross_hit);

    always_comb
    begin
        pend_next  = pend_reg;
        total_next = total_reg;
        if (cmd.start)
        begin
            pend_next  = '0;
            total_next = '0;
        end
        else if (p_vld_reg)
        begin
            if (p_end_reg)
            begin
                pend_next = '0;
                if (p_commit_reg)
                begin
                    total_next = total_reg + pend_sum;
                end
            end
            else
            begin
                pend_next = pend_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg  <= 1'b0;
            close_reg  <= 1'b0;
            len_reg    <= 2'd0;
            e_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            p_vld_reg  <= 1'b0;
            pend_reg   <= '0;
            total_reg  <= '0;
        end
        else
        begin
            q_vld_reg  <= q_vld_next;
            close_reg  <= close_next;
            len_reg    <= len_next;
            e_vld_reg  <= e_vld_next;
            d_vld_reg  <= e_vld_reg;
            p_vld_reg  <= d_vld_reg;
            pend_reg   <= pend_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qry_u_reg <= in_u;
            qry_v_reg <= in_v;
        end
        first_u_reg   <= first_u_next;
        first_v_reg   <= first_v_next;
        prev_u_reg    <= prev_u_next;
        prev_v_reg    <= prev_v_next;
        e_end_reg     <= e_end_next;
        e_commit_reg  <= e_commit_next;
        e_au_reg      <= e_au_next;
        e_av_reg      <= e_av_next;
        e_bu_reg      <= e_bu_next;
        e_bv_reg      <= e_bv_next;
        d_end_reg     <= e_end_reg;
        d_commit_reg  <= e_commit_reg;
        d_str_reg     <= (a_hi != b_hi);
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        d3_reg        <= d3_next;
        d4_reg        <= d4_next;
        p_end_reg     <= d_end_reg;
        p_commit_reg  <= d_commit_reg;
        p_str_reg     <= d_str_reg;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        if (cmd.res_load)
        begin
            inside_reg <= total_reg[0];
            cross_reg  <= (total_reg > TOT_W'(CROSS_MAX)) ? CROSS_MAX : total_reg[CROSS_W-1:0];
        end
    end

    assign inside_res = inside_reg;
    assign crossings  = cross_reg;

endmodule

### hw/rtl/pip_ctrl.sv
// controller: transaction decode, vertex count, store walk sequencing and result handshake
`timescale 1ns / 1ps

module pip_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [1:0]    action,
    output logic          res_valid,
    input  logic          res_ready,
    output logic          overflow,
    output pip_pkg::cmd_t cmd,
    input  pip_pkg::sts_t sts
);

    import pip_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0] rd_cnt_inc;
    logic             ovf_reg, ovf_next;
    logic             res_valid_reg, res_valid_next;
    logic             res_ovf_reg, res_ovf_next;
    logic             accept;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign rd_cnt_inc = rd_cnt_reg + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        res_ovf_next   = res_ovf_reg;
        cmd            = '0;
        cmd.addr       = count_reg[AW-1:0];

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_t'(action))
                        ACT_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            cmd.start   = 1'b1;
                            rd_cnt_next = '0;
                            state_next  = (count_reg == '0) ? S_DRAIN : S_WALK;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.rd_en = 1'b1;
                cmd.addr  = rd_cnt_reg[AW-1:0];
                if (!sts.stall)
                begin
                    rd_cnt_next = rd_cnt_inc;
                    if (rd_cnt_inc == count_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.res_load   = 1'b1;
                    res_valid_next = 1'b1;
                    res_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            res_ovf_reg   <= res_ovf_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign overflow  = res_ovf_reg;

endmodule

### hw/rtl/point_in_polygon_even_odd_top.sv
// load and clear transactions complete on acceptance; a query walks the store at one vertex
// a cycle while no closing edge stalls the read; an empty store skips the walk entirely
// a closing mark that ends a loop of two or more vertices stalls the read so that the
// closing edge can share the one crossing test pipeline
// one transaction in flight; loads and clears are taken while a result waits at the output
// asynchronous reset empties the store and clears the overflow flag; no clearing pass
`timescale 1ns / 1ps

module point_in_polygon_even_odd_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  action,
    input  logic signed [31:0]          point_u,
    input  logic signed [31:0]          point_v,
    input  logic                        closes_loop,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        inside_res,
    output logic [pip_pkg::CROSS_W-1:0] crossings,
    output logic                        overflow
);

    import pip_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (action),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .overflow  (overflow),
        .cmd       (cmd),
        .sts       (sts)
    );

    pip_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .point_u     (point_u),
        .point_v     (point_v),
        .closes_loop (closes_loop),
        .inside_res  (inside_res),
        .crossings   (crossings)
    );

    // the closing-edge hold lasts exactly one cycle
    a_stall_single: assert property (@(posedge clk) disable iff (!rst_n)
        sts.stall |=> !sts.stall)
        else $error("closing edge stall held longer than one cycle");

    a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("store written during a walk");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy)
        else $error("query started with edges still in the pipeline");

    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !sts.busy && !$past(sts.busy))
        else $error("result loaded before the crossing pipeline drained");

endmodule
